### sv/dsam_pkg.sv
// shared types and constants for the daily slot alarm matcher
package dsam_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } dsam_state_t;

  // request kinds carried on in_tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // field widths
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int TIME_W   = HOUR_W + MINUTE_W;
  localparam int GRAMS_W  = 12;
  localparam int TAG_W    = 16;
  localparam int DAY_W    = 9;
  localparam int SIDX_W   = 3;

  // packed stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  // largest legal time of day
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

endpackage

### sv/daily_slot_alarm_matcher.sv
// daily alarm slot table with a one-slot-per-cycle match scan
//
// channel   dir  ports                        contents
// -------   ---  ---------------------------  ---------------------------------------
// in_       in   in_tvalid/in_tready/tdata    slot write or time tick, kind in in_tuser
// out_      out  out_tvalid/out_tready/tdata  one result per request, due in out_tuser
//
// a slot write passes accept, a compare/update step on the shared comparator
//   and the hand-off to the output register; an index past the table skips the update
// a tick is accepted, then scans one slot per cycle through the shared comparator
//   until the first hit or the last slot, then hands off; an invalid time skips the scan
// in_tready is high only while the sequencer is idle; the output register may
//   still hold an untaken result then, and a finished request waits for it to drain
// rst_n is synchronous, active low; it disables every slot, clears the fired
//   flags and forgets the current day
module daily_slot_alarm_matcher #(
  parameter int SLOT_COUNT = 6,
  parameter int TAG_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot_index[2:0] slot_enabled[3] slot_hour[8:4] slot_minute[14:9]
  // slot_grams[26:15] slot_meal_tag[42:27] time_valid[43] day_of_year[52:44]
  // now_hour[57:53] now_minute[63:58]
  input  logic [dsam_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode[0]
  input  logic [dsam_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // due_grams[11:0] due_hour[16:12] due_minute[22:17] due_meal_tag[38:23] zero[39]
  output logic [dsam_pkg::OUT_DATA_W-1:0]  out_tdata,
  // due[0]
  output logic [dsam_pkg::OUT_USER_W-1:0]  out_tuser
);

  import dsam_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // unpacked input fields
  logic                mode;
  logic [SIDX_W-1:0]   f_slot_index;
  logic                f_slot_enabled;
  logic [HOUR_W-1:0]   f_slot_hour;
  logic [MINUTE_W-1:0] f_slot_minute;
  logic [GRAMS_W-1:0]  f_slot_grams;
  logic [TAG_W-1:0]    f_slot_meal_tag;
  logic                f_time_valid;
  logic [DAY_W-1:0]    f_day_of_year;
  logic [HOUR_W-1:0]   f_now_hour;
  logic [MINUTE_W-1:0] f_now_minute;

  assign mode            = in_tuser[0];
  assign f_slot_index    = in_tdata[2:0];
  assign f_slot_enabled  = in_tdata[3];
  assign f_slot_hour     = in_tdata[8:4];
  assign f_slot_minute   = in_tdata[14:9];
  assign f_slot_grams    = in_tdata[26:15];
  assign f_slot_meal_tag = in_tdata[42:27];
  assign f_time_valid    = in_tdata[43];
  assign f_day_of_year   = in_tdata[52:44];
  assign f_now_hour      = in_tdata[57:53];
  assign f_now_minute    = in_tdata[63:58];

  // tag and slot index resized to the stored widths
  logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
  logic [IDX_W+SIDX_W-1:0]   idx_in_ext;
  logic                      idx_ok;

  assign tag_in_ext = {{TAG_BITS{1'b0}}, f_slot_meal_tag};
  assign idx_in_ext = {{IDX_W{1'b0}}, f_slot_index};
  assign idx_ok     = ({3'b000, f_slot_index} < 6'(SLOT_COUNT));

  // control state
  dsam_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 day_known_r, day_known_nxt;
  logic [DAY_W-1:0]     last_day_r, last_day_nxt;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] fired_r, fired_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;

  // latched request
  logic                 item_en_r, item_en_nxt;
  logic [TIME_W-1:0]    item_time_r, item_time_nxt;
  logic [GRAMS_W-1:0]   item_grams_r, item_grams_nxt;
  logic [TAG_BITS-1:0]  item_tag_r, item_tag_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;

  // slot payload, only meaningful while the slot is active
  logic [TIME_W-1:0]    slot_time_r [SLOT_COUNT];
  logic [GRAMS_W-1:0]   slot_amt_r  [SLOT_COUNT];
  logic [TAG_BITS-1:0]  slot_tag_r  [SLOT_COUNT];
  logic                 slot_we;

  // pending result and output register
  logic                 res_due_r, res_due_nxt;
  logic [GRAMS_W-1:0]   res_grams_r, res_grams_nxt;
  logic [TIME_W-1:0]    res_time_r, res_time_nxt;
  logic [TAG_BITS-1:0]  res_tag_r, res_tag_nxt;
  logic                 out_load;
  logic                 out_due_r;
  logic [GRAMS_W-1:0]   out_grams_r;
  logic [TIME_W-1:0]    out_time_r;
  logic [TAG_BITS-1:0]  out_tag_r;

  // shared comparator: one slot read port, one wide equality
  logic [TIME_W-1:0]    rd_time;
  logic [GRAMS_W-1:0]   rd_amt;
  logic [TAG_BITS-1:0]  rd_tag;
  logic [TIME_W+GRAMS_W+TAG_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_eq;
  logic                 hit;

  assign rd_time = slot_time_r[idx_r];
  assign rd_amt  = slot_amt_r[idx_r];
  assign rd_tag  = slot_tag_r[idx_r];
  assign cmp_a   = {rd_time, rd_amt, rd_tag};
  // on a write compare the whole slot, on a scan only the time of day
  assign cmp_b   = (state_r == ST_WRITE) ? {item_time_r, item_grams_r, item_tag_r}
                                         : {now_r, rd_amt, rd_tag};
  assign cmp_eq  = (cmp_a == cmp_b);
  assign hit     = active_r[idx_r] && !fired_r[idx_r] && cmp_eq;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    day_known_nxt  = day_known_r;
    last_day_nxt   = last_day_r;
    active_nxt     = active_r;
    fired_nxt      = fired_r;
    out_tvalid_nxt = out_tvalid_r;
    item_en_nxt    = item_en_r;
    item_time_nxt  = item_time_r;
    item_grams_nxt = item_grams_r;
    item_tag_nxt   = item_tag_r;
    now_nxt        = now_r;
    res_due_nxt    = res_due_r;
    res_grams_nxt  = res_grams_r;
    res_time_nxt   = res_time_r;
    res_tag_nxt    = res_tag_r;
    slot_we        = 1'b0;
    out_load       = 1'b0;
    in_tready      = 1'b0;

    // drain the output register
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // every request starts from the zero result
          res_due_nxt    = 1'b0;
          res_grams_nxt  = '0;
          res_time_nxt   = '0;
          res_tag_nxt    = '0;
          item_en_nxt    = f_slot_enabled && (f_slot_grams != '0) &&
                           (f_slot_hour <= HOUR_MAX) && (f_slot_minute <= MINUTE_MAX);
          item_time_nxt  = {f_slot_hour, f_slot_minute};
          item_grams_nxt = f_slot_grams;
          item_tag_nxt   = tag_in_ext[TAG_BITS-1:0];
          now_nxt        = {f_now_hour, f_now_minute};
          if (mode == MODE_WRITE) begin
            idx_nxt   = idx_in_ext[IDX_W-1:0];
            state_nxt = idx_ok ? ST_WRITE : ST_DONE;
          end else if (f_time_valid) begin
            // day tracking, first valid day is only recorded
            if (!day_known_r) begin
              day_known_nxt = 1'b1;
              last_day_nxt  = f_day_of_year;
            end else if (f_day_of_year != last_day_r) begin
              last_day_nxt = f_day_of_year;
              fired_nxt    = '0;
            end
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        slot_we = 1'b1;
        if (!item_en_r) begin
          active_nxt[idx_r] = 1'b0;
          fired_nxt[idx_r]  = 1'b0;
        end else begin
          if (!active_r[idx_r] || !cmp_eq) begin
            fired_nxt[idx_r] = 1'b0;
          end
          active_nxt[idx_r] = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (hit) begin
          fired_nxt[idx_r] = 1'b1;
          res_due_nxt      = 1'b1;
          res_grams_nxt    = rd_amt;
          res_time_nxt     = rd_time;
          res_tag_nxt      = rd_tag;
          state_nxt        = ST_DONE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      day_known_r  <= 1'b0;
      last_day_r   <= '0;
      active_r     <= '0;
      fired_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      day_known_r  <= day_known_nxt;
      last_day_r   <= last_day_nxt;
      active_r     <= active_nxt;
      fired_r      <= fired_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_en_r    <= item_en_nxt;
    item_time_r  <= item_time_nxt;
    item_grams_r <= item_grams_nxt;
    item_tag_r   <= item_tag_nxt;
    now_r        <= now_nxt;
    res_due_r    <= res_due_nxt;
    res_grams_r  <= res_grams_nxt;
    res_time_r   <= res_time_nxt;
    res_tag_r    <= res_tag_nxt;
    if (slot_we) begin
      // a disabled slot stores zero contents
      slot_time_r[idx_r] <= item_en_r ? item_time_r  : '0;
      slot_amt_r[idx_r]  <= item_en_r ? item_grams_r : '0;
      slot_tag_r[idx_r]  <= item_en_r ? item_tag_r   : '0;
    end
    if (out_load) begin
      out_due_r   <= res_due_r;
      out_grams_r <= res_grams_r;
      out_time_r  <= res_time_r;
      out_tag_r   <= res_tag_r;
    end
  end

  // output packing, tag resized to the port width
  logic [TAG_BITS+TAG_W-1:0] tag_out_ext;

  assign tag_out_ext = {{TAG_W{1'b0}}, out_tag_r};
  assign out_tvalid  = out_tvalid_r;
  assign out_tuser   = out_due_r;
  assign out_tdata   = {1'b0, tag_out_ext[TAG_W-1:0], out_time_r[MINUTE_W-1:0],
                        out_time_r[TIME_W-1:MINUTE_W], out_grams_r};

  // a fired request always carries a usable slot
  a_due_grams: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[11:0] != '0))
    else $error("due result with zero amount");

  a_due_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      ((out_tdata[16:12] <= HOUR_MAX) && (out_tdata[22:17] <= MINUTE_MAX)))
    else $error("due result with out-of-range time");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("non-due result with nonzero payload");

  a_fired_active: assert property (@(posedge clk) disable iff (!rst_n)
    (fired_r & ~active_r) == '0)
    else $error("fired flag set on a disabled slot");

  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && hit) |=> (fired_r[$past(idx_r)] && state_r == ST_DONE))
    else $error("scan hit did not mark the slot fired");

endmodule

### tb/dsam_feed_checker.sv
// request/result checker for the daily slot alarm matcher
module dsam_feed_checker
  import dsam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  output int                    fail_count,
  output int                    pending,
  output int                    fired_count
);

  localparam int SLOTS = 6;

  typedef struct packed {
    logic                active;
    logic                fired;
    logic [TIME_W-1:0]   at;
    logic [GRAMS_W-1:0]  grams;
    logic [TAG_W-1:0]    tag;
  } slot_t;

  typedef struct packed {
    logic                due;
    logic [GRAMS_W-1:0]  grams;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [TAG_W-1:0]    tag;
  } due_t;

  slot_t            slot_tab [SLOTS];
  logic [DAY_W-1:0] seen_day;
  logic             day_valid;
  due_t             due_expected [$];
  int               errors = 0;
  int               fires  = 0;

  // advances the slot table by one request and returns the result it should give
  function automatic due_t feed_outcome(input logic mode, input logic [IN_DATA_W-1:0] d);
    logic [SIDX_W-1:0]   idx;
    logic                en;
    logic [HOUR_W-1:0]   hr;
    logic [MINUTE_W-1:0] mn;
    logic [GRAMS_W-1:0]  g;
    logic [TAG_W-1:0]    tg;
    logic [DAY_W-1:0]    day;
    logic [TIME_W-1:0]   now;
    due_t                res;
    int                  i;
    idx = d[2:0];
    hr  = d[8:4];
    mn  = d[14:9];
    g   = d[26:15];
    tg  = d[42:27];
    day = d[52:44];
    now = {d[57:53], d[63:58]};
    res = '0;
    if (mode == MODE_WRITE) begin
      if (idx < SLOTS) begin
        en = d[3] && (g != '0) && (hr <= HOUR_MAX) && (mn <= MINUTE_MAX);
        if (!en) begin
          slot_tab[idx] = '0;
        end else begin
          // same contents on an active slot keep the fired flag
          if (!slot_tab[idx].active || slot_tab[idx].at != {hr, mn} ||
              slot_tab[idx].grams != g || slot_tab[idx].tag != tg)
            slot_tab[idx].fired = 1'b0;
          slot_tab[idx].active = 1'b1;
          slot_tab[idx].at     = {hr, mn};
          slot_tab[idx].grams  = g;
          slot_tab[idx].tag    = tg;
        end
      end
    end else if (d[43]) begin
      if (!day_valid) begin
        day_valid = 1'b1;
        seen_day  = day;
      end else if (day != seen_day) begin
        seen_day = day;
        for (i = 0; i < SLOTS; i++) slot_tab[i].fired = 1'b0;
      end
      for (i = 0; i < SLOTS; i++) begin
        if (!res.due && slot_tab[i].active && !slot_tab[i].fired && slot_tab[i].at == now) begin
          slot_tab[i].fired = 1'b1;
          res.due    = 1'b1;
          res.grams  = slot_tab[i].grams;
          res.hour   = slot_tab[i].at[TIME_W-1:MINUTE_W];
          res.minute = slot_tab[i].at[MINUTE_W-1:0];
          res.tag    = slot_tab[i].tag;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    due_t want;
    int   i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) slot_tab[i] = '0;
      seen_day  = '0;
      day_valid = 1'b0;
      due_expected.delete();
    end else begin
      if (in_tvalid && in_tready)
        due_expected.push_back(feed_outcome(in_tuser[0], in_tdata));
      if (out_tvalid && out_tready) begin
        if (out_tuser[0] === 1'b1) fires++;
        if (due_expected.size() == 0) begin
          errors++;
          $error("result arrived with no request outstanding");
        end else begin
          want = due_expected.pop_front();
          check_field("due", 32'(want.due), 32'(out_tuser[0]));
          check_field("due_grams", 32'(want.grams), 32'(out_tdata[11:0]));
          check_field("due_hour", 32'(want.hour), 32'(out_tdata[16:12]));
          check_field("due_minute", 32'(want.minute), 32'(out_tdata[22:17]));
          check_field("due_meal_tag", 32'(want.tag), 32'(out_tdata[38:23]));
          check_field("pad", 32'd0, 32'(out_tdata[39]));
        end
      end
    end
    fail_count  <= errors;
    pending     <= due_expected.size();
    fired_count <= fires;
  end

endmodule

### tb/daily_slot_alarm_matcher_tb.sv
// stimulus and verdict for the daily slot alarm matcher
module daily_slot_alarm_matcher_tb;
  import dsam_pkg::*;

  // one request as laid out on in_tdata, last field in the top bits
  typedef struct packed {
    logic [MINUTE_W-1:0] now_minute;
    logic [HOUR_W-1:0]   now_hour;
    logic [DAY_W-1:0]    day;
    logic                time_valid;
    logic [TAG_W-1:0]    tag;
    logic [GRAMS_W-1:0]  grams;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic                en;
    logic [SIDX_W-1:0]   idx;
  } req_fields_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // slot_index slot_enabled slot_hour slot_minute slot_grams slot_meal_tag
  // time_valid day_of_year now_hour now_minute
  logic [IN_DATA_W-1:0]  in_tdata;
  // mode
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // due_grams due_hour due_minute due_meal_tag zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // due
  logic [OUT_USER_W-1:0] out_tuser;

  int   fail_count;
  int   pending;
  int   fired_count;
  int   writes_sent = 0;
  int   ticks_sent  = 0;
  // no idling on either side while set
  logic quiet;

  always #5 clk = ~clk;

  daily_slot_alarm_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dsam_feed_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .fired_count (fired_count)
  );

  // result side drops ready at random, about 22 percent of the time, unless quiet
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 22);
  end

  // presents one request and holds it until the handshake; valid is only
  // lowered when a random gap goes in front of the request
  task automatic drive(input logic mode, input req_fields_t r);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
  endtask

  // slot write; the tick fields carry random noise the block must ignore
  task automatic put_slot(input logic [SIDX_W-1:0] idx, input logic en,
                          input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn,
                          input logic [GRAMS_W-1:0] g, input logic [TAG_W-1:0] tg);
    req_fields_t r;
    r       = {$urandom, $urandom};
    r.idx   = idx;
    r.en    = en;
    r.hour  = hr;
    r.minute = mn;
    r.grams = g;
    r.tag   = tg;
    writes_sent++;
    drive(MODE_WRITE, r);
  endtask

  // time tick; the slot fields carry random noise the block must ignore
  task automatic send_tick(input logic valid, input logic [DAY_W-1:0] day,
                           input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn);
    req_fields_t r;
    r            = {$urandom, $urandom};
    r.time_valid = valid;
    r.day        = day;
    r.now_hour   = hr;
    r.now_minute = mn;
    ticks_sent++;
    drive(MODE_TICK, r);
  endtask

  // stop sending and wait until every outstanding request has its result;
  // the first edge lets the checker count the request just accepted
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [HOUR_W-1:0]   pool_h [4];
    logic [MINUTE_W-1:0] pool_m [4];
    logic [GRAMS_W-1:0]  pool_g [3];
    logic [TAG_W-1:0]    pool_t [3];
    logic [HOUR_W-1:0]   hr;
    logic [MINUTE_W-1:0] mn;
    logic [GRAMS_W-1:0]  g;
    logic [TAG_W-1:0]    tg;
    logic [SIDX_W-1:0]   idx;
    logic [DAY_W-1:0]    day;
    int                  n;
    int                  p;
    int                  roll;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_WRITE;
    quiet     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: invalid tick before any day is known, then the first valid tick
    send_tick(1'b0, 9'd0, 5'd0, 6'd0);
    send_tick(1'b1, 9'd0, 5'd0, 6'd0);
    // extreme slots at midnight and one minute before
    put_slot(3'd0, 1'b1, 5'd0, 6'd0, 12'hFFF, 16'hFFFF);
    put_slot(3'd5, 1'b1, 5'd23, 6'd59, 12'd1, 16'h0000);
    // indexes past the table are dropped
    put_slot(3'd6, 1'b1, 5'd0, 6'd0, 12'd5, 16'h1234);
    put_slot(3'd7, 1'b1, 5'd0, 6'd0, 12'd5, 16'h1234);
    // enabled but unusable: zero amount, hour and minute past their range
    put_slot(3'd1, 1'b1, 5'd12, 6'd30, 12'd0, 16'hAAAA);
    put_slot(3'd2, 1'b1, 5'd31, 6'd63, 12'd100, 16'h5555);
    put_slot(3'd2, 1'b1, 5'd5, 6'd60, 12'd100, 16'h5555);
    // fires once, then stays quiet on the same day
    send_tick(1'b1, 9'd0, 5'd0, 6'd0);
    send_tick(1'b1, 9'd0, 5'd0, 6'd0);
    // rewriting identical contents keeps the fired flag
    put_slot(3'd0, 1'b1, 5'd0, 6'd0, 12'hFFF, 16'hFFFF);
    send_tick(1'b1, 9'd0, 5'd0, 6'd0);
    // a changed tag rearms the slot
    put_slot(3'd0, 1'b1, 5'd0, 6'd0, 12'hFFF, 16'hFFFE);
    send_tick(1'b1, 9'd0, 5'd0, 6'd0);
    // invalid time on a matching minute does nothing
    send_tick(1'b0, 9'd0, 5'd23, 6'd59);
    send_tick(1'b1, 9'd0, 5'd23, 6'd59);
    // new day rearms everything
    send_tick(1'b1, 9'd365, 5'd0, 6'd0);
    // two slots share a minute: lowest index first, one per tick
    put_slot(3'd3, 1'b1, 5'd23, 6'd59, 12'd77, 16'h0F0F);
    send_tick(1'b1, 9'd511, 5'd23, 6'd59);
    send_tick(1'b1, 9'd511, 5'd23, 6'd59);
    send_tick(1'b1, 9'd511, 5'd23, 6'd59);
    // tick time past its range never matches
    send_tick(1'b1, 9'd511, 5'd31, 6'd63);
    // disabling a slot
    put_slot(3'd5, 1'b0, 5'd23, 6'd59, 12'd1, 16'h0000);
    settle();

    // random part: small pools of times, amounts and tags so that ticks hit
    // slots often and rewrites sometimes repeat the stored contents
    pool_h[0] = 5'd0;
    pool_m[0] = 6'd0;
    pool_h[1] = 5'd23;
    pool_m[1] = 6'd59;
    for (p = 2; p < 4; p++) begin
      pool_h[p] = HOUR_W'($urandom_range(23));
      pool_m[p] = MINUTE_W'($urandom_range(59));
    end
    for (p = 0; p < 3; p++) begin
      pool_g[p] = GRAMS_W'($urandom_range(4095, 1));
      pool_t[p] = TAG_W'($urandom);
    end
    day = DAY_W'($urandom);

    for (n = 0; n < 800; n++) begin
      // full-throughput stretch on both sides
      if (n == 250) quiet <= 1'b1;
      if (n == 400) quiet <= 1'b0;
      // hold off until the block has drained completely
      if (n == 550) settle();

      if ($urandom_range(99) < 80) begin
        p  = $urandom_range(3);
        hr = pool_h[p];
        mn = pool_m[p];
      end else begin
        hr = HOUR_W'($urandom);
        mn = MINUTE_W'($urandom);
      end

      if ($urandom_range(99) < 40) begin
        idx  = ($urandom_range(99) < 90) ? SIDX_W'($urandom_range(5))
                                         : SIDX_W'($urandom_range(7, 6));
        roll = $urandom_range(99);
        if (roll < 8)       g = '0;
        else if (roll < 60) g = pool_g[$urandom_range(2)];
        else                g = GRAMS_W'($urandom);
        tg = ($urandom_range(99) < 60) ? pool_t[$urandom_range(2)] : TAG_W'($urandom);
        put_slot(idx, $urandom_range(99) < 85, hr, mn, g, tg);
      end else begin
        roll = $urandom_range(99);
        if (roll < 12)      day = day + 1'b1;
        else if (roll < 20) day = DAY_W'($urandom);
        send_tick($urandom_range(99) < 90, day, hr, mn);
      end
    end

    settle();
    repeat (16) @(posedge clk);

    $display("run covered %0d slot writes and %0d time ticks", writes_sent, ticks_sent);
    $display("%0d ticks fired a slot", fired_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // generous cap, far above the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### daily_slot_alarm_matcher.f
sv/dsam_pkg.sv
sv/daily_slot_alarm_matcher.sv
tb/dsam_feed_checker.sv
tb/daily_slot_alarm_matcher_tb.sv
